### design/pcmrb_pkg.sv
// Shared constants, types and the arctangent table of the polar range binning block.
package pcmrb_pkg;

   localparam int NUM_BINS_DEF   = 360;
   localparam int ANGLE_ITER_DEF = 20;

   localparam int COORD_W = 32;
   localparam int RANGE_W = 32;
   localparam int INDEX_W = 9;
   localparam int CNT_W   = 5;
   localparam int VEC_W   = 35;
   localparam int ANG_W   = 34;
   localparam int RAM_W   = RANGE_W + 1;

   localparam logic [RANGE_W-1:0] EMPTY_RESET = 32'h0033_0000;

   localparam logic signed [ANG_W-1:0] QUARTER_TURN = 34'sh0_4000_0000;
   localparam logic signed [ANG_W-1:0] HALF_TURN    = 34'sh0_8000_0000;
   localparam logic signed [ANG_W:0]   HALF_TURN_X  = 35'sh0_8000_0000;

   typedef enum logic {
      OP_ACCUM = 1'b0,
      OP_READ  = 1'b1
   } opcode_type;

   localparam logic [31:0] ATAN_TURNS [32] = '{
      32'd536870912, 32'd316933405, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335086,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41721,     32'd20860,
      32'd10430,     32'd5215,      32'd2607,      32'd1303,
      32'd651,       32'd325,       32'd162,       32'd81,
      32'd40,        32'd20,        32'd10,        32'd5,
      32'd2,         32'd1,         32'd0,         32'd0
   };

endpackage

### design/pcmrb_req_if.sv
// Request channel of the polar range binning block.
interface pcmrb_req_if;
   logic                                      valid;
   logic                                      ready;
   logic                                      opcode;
   logic signed [pcmrb_pkg::COORD_W-1:0]      point_x;
   logic signed [pcmrb_pkg::COORD_W-1:0]      point_y;
   logic        [pcmrb_pkg::INDEX_W-1:0]      sector_index;

   modport source (output valid, output opcode, output point_x, output point_y,
                   output sector_index, input ready);
   modport sink   (input valid, input opcode, input point_x, input point_y,
                   input sector_index, output ready);
endinterface

### design/pcmrb_rsp_if.sv
// Response channel of the polar range binning block.
interface pcmrb_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [pcmrb_pkg::RANGE_W-1:0]     sector_range;
   logic                              sector_hit;

   modport source (output valid, output sector_range, output sector_hit, input ready);
   modport sink   (input valid, input sector_range, input sector_hit, output ready);
endinterface

### design/point_cloud_to_polar_min_range_bins_top.sv
// Accumulate request: from acceptance to the next ready it goes through two squares, one sum,
// 32 square root steps shared with up to ANGLE_ITERATIONS CORDIC steps, sector multiply, RAM read, RAM update.
// Read request: after acceptance it steps through S_RLOOK and S_RUPD; response valid and ready rise together;
// both wait longer while an earlier response still sits in the response register.
// A new request is taken only when the block is back in its idle state.
// Synchronous active-high reset; afterwards a clearing pass over all NUM_BINS sectors
// empties every sector before the first request is taken.
module point_cloud_to_polar_min_range_bins_top #(
   parameter int NUM_BINS         = pcmrb_pkg::NUM_BINS_DEF,
   parameter int ANGLE_ITERATIONS = pcmrb_pkg::ANGLE_ITER_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [pcmrb_pkg::RANGE_W-1:0] csr_write_data,
   pcmrb_req_if.sink                     req_chan,
   pcmrb_rsp_if.source                   rsp_chan
);

   localparam int AW      = $clog2(NUM_BINS);
   localparam int VEC_W   = pcmrb_pkg::VEC_W;
   localparam int ANG_W   = pcmrb_pkg::ANG_W;
   localparam int CNT_W   = pcmrb_pkg::CNT_W;
   localparam int RANGE_W = pcmrb_pkg::RANGE_W;
   localparam int RAM_W   = pcmrb_pkg::RAM_W;
   localparam logic [AW-1:0]    LAST_BIN  = AW'(NUM_BINS - 1);
   localparam logic [CNT_W-1:0] LAST_STEP = '1;
   localparam logic [CNT_W:0]   NUM_STEPS = (CNT_W + 1)'(ANGLE_ITERATIONS);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_SQX, S_SQY, S_SUM, S_ITER,
      S_SECT, S_LOOK, S_UPD, S_RLOOK, S_RUPD
   } state_type;

   state_type state_ff, state_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic [RANGE_W-1:0] empty_ff, empty_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RANGE_W-1:0] rsp_range_ff, rsp_range_in;
   logic               rsp_hit_ff, rsp_hit_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [AW-1:0]      addr_ff, addr_in;
   logic               oor_ff, oor_in;

   logic [31:0]             ax_ff, ax_in, ay_ff, ay_in;
   logic signed [VEC_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [ANG_W-1:0] cz_ff, cz_in;
   logic                    axis_ff, axis_in;
   logic [63:0]             prod_ff, prod_in;
   logic [63:0]             sq_ff, sq_in;
   logic [35:0]             rem_ff, rem_in;
   logic [31:0]             root_ff, root_in;

   logic                accept;
   logic [31:0]         mul_a, mul_b;
   logic signed [ANG_W:0] u_wide;
   logic [31:0]         u_clamp;
   logic                cordic_run;
   logic signed [VEC_W-1:0] step_dx, step_dy;
   logic signed [ANG_W-1:0] step_t;
   logic [35:0]         rem_sh, trial;
   logic                root_ge;
   logic signed [VEC_W-1:0] px, py;
   logic [31:0]         idx_wide;

   logic               ram_we, ram_re;
   logic [AW-1:0]      ram_waddr, ram_raddr;
   logic [RAM_W-1:0]   ram_wdata, ram_rdata;

   pcmrb_ram #(
      .WIDTH (RAM_W),
      .DEPTH (NUM_BINS)
   ) u_sector_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_chan.ready        = (state_ff == S_IDLE);
   assign accept                = req_chan.valid && (state_ff == S_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.sector_range = rsp_range_ff;
   assign rsp_chan.sector_hit   = rsp_hit_ff;

   assign px       = VEC_W'(req_chan.point_x);
   assign py       = VEC_W'(req_chan.point_y);
   assign idx_wide = 32'(req_chan.sector_index);

   // Shared multiplier: squares, then the sector scale.
   always_comb begin
      unique case (state_ff)
         S_SQX: begin
            mul_a = ax_ff;
            mul_b = ax_ff;
         end
         S_SQY: begin
            mul_a = ay_ff;
            mul_b = ay_ff;
         end
         default: begin
            mul_a = u_clamp;
            mul_b = 32'(NUM_BINS);
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   assign u_wide = {cz_ff[ANG_W-1], cz_ff} + pcmrb_pkg::HALF_TURN_X;

   always_comb begin
      priority if (u_wide[ANG_W]) begin
         u_clamp = '0;
      end else if (|u_wide[ANG_W-1:32]) begin
         u_clamp = '1;
      end else begin
         u_clamp = u_wide[31:0];
      end
   end

   assign cordic_run = (state_ff == S_ITER) && !axis_ff && ({1'b0, cnt_ff} < NUM_STEPS);
   assign step_dx    = cy_ff >>> cnt_ff;
   assign step_dy    = cx_ff >>> cnt_ff;
   assign step_t     = ANG_W'(pcmrb_pkg::ATAN_TURNS[cnt_ff]);

   assign rem_sh  = {rem_ff[33:0], sq_ff[63:62]};
   assign trial   = {2'b00, root_ff, 2'b01};
   assign root_ge = (rem_sh >= trial);

   // Datapath next values.
   always_comb begin
      ax_in   = ax_ff;
      ay_in   = ay_ff;
      cx_in   = cx_ff;
      cy_in   = cy_ff;
      cz_in   = cz_ff;
      axis_in = axis_ff;
      sq_in   = sq_ff;
      rem_in  = rem_ff;
      root_in = root_ff;

      if (accept) begin
         ax_in   = px[VEC_W-1] ? 32'(-px) : px[31:0];
         ay_in   = py[VEC_W-1] ? 32'(-py) : py[31:0];
         axis_in = 1'b0;
         cx_in   = px;
         cy_in   = py;
         cz_in   = '0;
         priority if (py == '0) begin
            axis_in = 1'b1;
            cz_in   = px[VEC_W-1] ? pcmrb_pkg::HALF_TURN : '0;
         end else if (px == '0) begin
            axis_in = 1'b1;
            cz_in   = py[VEC_W-1] ? -pcmrb_pkg::QUARTER_TURN : pcmrb_pkg::QUARTER_TURN;
         end else if (px[VEC_W-1]) begin
            if (!py[VEC_W-1]) begin
               cx_in = py;
               cy_in = -px;
               cz_in = pcmrb_pkg::QUARTER_TURN;
            end else begin
               cx_in = -py;
               cy_in = px;
               cz_in = -pcmrb_pkg::QUARTER_TURN;
            end
         end else begin
            cz_in = '0;
         end
      end

      if (cordic_run) begin
         if (!cy_ff[VEC_W-1]) begin
            cx_in = cx_ff + step_dx;
            cy_in = cy_ff - step_dy;
            cz_in = cz_ff + step_t;
         end else begin
            cx_in = cx_ff - step_dx;
            cy_in = cy_ff + step_dy;
            cz_in = cz_ff - step_t;
         end
      end

      unique case (state_ff)
         S_SQY: begin
            sq_in = prod_ff;
         end
         S_SUM: begin
            sq_in   = sq_ff + prod_ff;
            rem_in  = '0;
            root_in = '0;
         end
         S_ITER: begin
            sq_in = {sq_ff[61:0], 2'b00};
            if (root_ge) begin
               rem_in  = rem_sh - trial;
               root_in = {root_ff[30:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[30:0], 1'b0};
            end
         end
         default: begin
            sq_in = sq_ff;
         end
      endcase
   end

   // Sequencer next values.
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      empty_in     = empty_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_range_in = rsp_range_ff;
      rsp_hit_in   = rsp_hit_ff;
      cnt_in       = cnt_ff;
      addr_in      = addr_ff;
      oor_in       = oor_ff;
      ram_we       = 1'b0;
      ram_waddr    = addr_ff;
      ram_wdata    = '0;
      ram_re       = 1'b0;
      ram_raddr    = addr_ff;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_write_enable) begin
         empty_in = csr_write_data;
      end

      unique case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == LAST_BIN) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_chan.valid) begin
               if (req_chan.opcode == pcmrb_pkg::OP_READ) begin
                  oor_in   = (idx_wide >= 32'(NUM_BINS));
                  addr_in  = idx_wide[AW-1:0];
                  state_in = S_RLOOK;
               end else begin
                  state_in = S_SQX;
               end
            end
         end
         S_SQX: begin
            state_in = S_SQY;
         end
         S_SQY: begin
            state_in = S_SUM;
         end
         S_SUM: begin
            cnt_in   = '0;
            state_in = S_ITER;
         end
         S_ITER: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) begin
               state_in = S_SECT;
            end
         end
         S_SECT: begin
            state_in = S_LOOK;
         end
         S_LOOK: begin
            ram_re    = 1'b1;
            ram_raddr = prod_ff[32 +: AW];
            addr_in   = prod_ff[32 +: AW];
            state_in  = S_UPD;
         end
         S_UPD: begin
            if (!ram_rdata[RANGE_W] || (root_ff < ram_rdata[RANGE_W-1:0])) begin
               ram_we    = 1'b1;
               ram_wdata = {1'b1, root_ff};
            end
            state_in = S_IDLE;
         end
         S_RLOOK: begin
            ram_re   = 1'b1;
            state_in = S_RUPD;
         end
         S_RUPD: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               if (!oor_ff && ram_rdata[RANGE_W]) begin
                  rsp_hit_in   = 1'b1;
                  rsp_range_in = ram_rdata[RANGE_W-1:0];
                  ram_we       = 1'b1;
                  ram_wdata    = {1'b0, ram_rdata[RANGE_W-1:0]};
               end else begin
                  rsp_hit_in   = 1'b0;
                  rsp_range_in = empty_ff;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         empty_ff     <= pcmrb_pkg::EMPTY_RESET;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         empty_ff     <= empty_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
      rsp_range_ff <= rsp_range_in;
      rsp_hit_ff   <= rsp_hit_in;
      addr_ff      <= addr_in;
      oor_ff       <= oor_in;
   end

   always_ff @(posedge clock) begin
      ax_ff   <= ax_in;
      ay_ff   <= ay_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      cz_ff   <= cz_in;
      axis_ff <= axis_in;
      prod_ff <= prod_in;
      sq_ff   <= sq_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

endmodule

### design/pcmrb_ram.sv
// Generic single write port, single read port RAM with registered read data.
module pcmrb_ram #(
   parameter int WIDTH = pcmrb_pkg::RAM_W,
   parameter int DEPTH = pcmrb_pkg::NUM_BINS_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
